// ===== hdl/bbwdt_pkg.sv =====
// Shared types and constants for the bark/bite watchdog timer.
// Holds the counter width, the register offsets and the command codes.
// No dependencies.
package bbwdt_pkg;

  // Width of the counter and of the bark and bite times.
  localparam int COUNT_WIDTH = 20;

  // Field widths on the streams.
  localparam int CMD_WIDTH   = 2;
  localparam int ADDR_WIDTH  = 12;
  localparam int WDATA_WIDTH = 32;
  localparam int RDATA_WIDTH = 21;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_BITS  = ADDR_WIDTH + WDATA_WIDTH;
  localparam int IN_DATA_WIDTH = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = RDATA_WIDTH + 2;
  localparam int OUT_DATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Register byte offsets.
  localparam logic [ADDR_WIDTH-1:0] OFS_RESET  = 12'h004;
  localparam logic [ADDR_WIDTH-1:0] OFS_ENABLE = 12'h008;
  localparam logic [ADDR_WIDTH-1:0] OFS_STATUS = 12'h00C;
  localparam logic [ADDR_WIDTH-1:0] OFS_BARK   = 12'h010;
  localparam logic [ADDR_WIDTH-1:0] OFS_BITE   = 12'h014;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

// ===== hdl/bark_bite_watchdog_timer.sv =====
// Bark/bite watchdog timer: counter, enable, bark and bite times behind a
// request stream of ticks, register reads and register writes.
// Depends on bbwdt_pkg.

// Usage
// Every request on the slave stream is a watchdog tick, a register read or a
// register write, chosen by s_axis_tuser. Each request gives exactly one result
// on the master stream: the read data (zero for ticks, writes and unmapped
// offsets) and the bark and bite levels as they stand after the request.
// The result is registered: a request that is accepted has its result on the master
// stream in the following cycle. Throughput is one request per cycle unless the
// receiver stalls; the watchdog state and the result register are both written at
// the accepting edge by a single pass of compare and increment logic.
// The result register is the only buffer. While the receiver stalls with a
// result pending, s_axis_tready is low; it is high whenever the result
// register is empty or is being emptied in the same cycle, so a steady stream
// flows without bubbles.
// A synchronous reset clears the counter, the enable bit, both times and the
// result valid flag. With the enable bit clear both outputs read zero; the
// counter holds its value while disabled and saturates at all ones.
module bark_bite_watchdog_timer
  import bbwdt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: address[11:0], write_data[43:12], zero fill.
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
  // Fields from bit 0 up: command[1:0].
  input  logic [CMD_WIDTH-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0 up: read_data[20:0], bark_irq[21], bite_reset[22], zero fill.
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  // Watchdog state.
  count_t tick_count;
  logic   enable_bit;
  count_t bark_limit;
  count_t bite_limit;

  count_t tick_count_next;
  logic   enable_bit_next;
  count_t bark_limit_next;
  count_t bite_limit_next;

  // Result register.
  logic                   out_valid;
  logic [RDATA_WIDTH-1:0] out_read_data;
  logic                   out_bark;
  logic                   out_bite;

  logic [RDATA_WIDTH-1:0] read_data_next;
  logic                   bark_next;
  logic                   bite_next;

  // Unpacked request fields.
  cmd_t                   command;
  logic [ADDR_WIDTH-1:0]  address;
  logic [WDATA_WIDTH-1:0] write_data;
  logic                   accept;
  logic                   reset_write;

  // Zero-extended views used to build read values at any counter width.
  logic [WDATA_WIDTH:0]   status_wide;
  logic [WDATA_WIDTH:0]   bark_wide;
  logic [WDATA_WIDTH:0]   bite_wide;

  assign command    = cmd_t'(s_axis_tuser);
  assign address    = s_axis_tdata[ADDR_WIDTH-1:0];
  assign write_data = s_axis_tdata[ADDR_WIDTH +: WDATA_WIDTH];

  // A new request is taken whenever the result register is free or drains now.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign reset_write = (command == CMD_WRITE) && (address == OFS_RESET) && write_data[0];

  assign status_wide = (WDATA_WIDTH + 1)'({tick_count, 1'b0});
  assign bark_wide   = (WDATA_WIDTH + 1)'(bark_limit);
  assign bite_wide   = (WDATA_WIDTH + 1)'(bite_limit);

  // Next state and result for the request on the input.
  always_comb begin
    tick_count_next = tick_count;
    enable_bit_next = enable_bit;
    bark_limit_next = bark_limit;
    bite_limit_next = bite_limit;
    read_data_next  = '0;
    case (command)
      CMD_TICK: begin
        // Saturating count, only while enabled.
        if (enable_bit && (tick_count != '1)) begin
          tick_count_next = tick_count + count_t'(1);
        end
      end
      CMD_READ: begin
        case (address)
          OFS_ENABLE: read_data_next = RDATA_WIDTH'(enable_bit);
          OFS_STATUS: read_data_next = status_wide[RDATA_WIDTH-1:0];
          OFS_BARK:   read_data_next = bark_wide[RDATA_WIDTH-1:0];
          OFS_BITE:   read_data_next = bite_wide[RDATA_WIDTH-1:0];
          default:    read_data_next = '0;
        endcase
      end
      CMD_WRITE: begin
        case (address)
          OFS_RESET: begin
            if (write_data[0]) begin
              tick_count_next = '0;
            end
          end
          OFS_ENABLE: enable_bit_next = write_data[0];
          OFS_BARK:   bark_limit_next = write_data[COUNT_WIDTH-1:0];
          OFS_BITE:   bite_limit_next = write_data[COUNT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    // Both levels are taken from the state after this request.
    bark_next = enable_bit_next && (tick_count_next >= bark_limit_next);
    bite_next = enable_bit_next && (tick_count_next >= bite_limit_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      enable_bit <= 1'b0;
      bark_limit <= '0;
      bite_limit <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        tick_count <= tick_count_next;
        enable_bit <= enable_bit_next;
        bark_limit <= bark_limit_next;
        bite_limit <= bite_limit_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data <= read_data_next;
      out_bark      <= bark_next;
      out_bite      <= bite_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_WIDTH'({out_bite, out_bark, out_read_data});

  // A request always produces a pending result.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("result missing after accepted request");

  // A reset write clears the counter.
  assert property (@(posedge clk) disable iff (rst)
    (accept && reset_write) |=> (tick_count == '0))
    else $error("counter not cleared by reset write");

  // Outside a reset write, the counter never goes down.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !reset_write) |=> (tick_count >= $past(tick_count)))
    else $error("counter decreased without reset write");

  // An enabled, unsaturated tick adds exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_TICK) && enable_bit && (tick_count != '1))
    |=> (tick_count == count_t'($past(tick_count) + count_t'(1))))
    else $error("tick did not advance counter by one");

  // A disabled watchdog reports neither bark nor bite.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !enable_bit_next) |=> (!out_bark && !out_bite))
    else $error("bark or bite raised while disabled");

endmodule

// ===== sim/tb_bark_bite_watchdog_timer.sv =====
// Self-checking testbench for the bark/bite watchdog timer request stream.
// Drives ticks, register reads and register writes and checks every result.
// Depends on bbwdt_pkg and bark_bite_watchdog_timer.
`timescale 1ns / 1ps

module tb_bark_bite_watchdog_timer;
  import bbwdt_pkg::*;

  localparam int RESET_CYCLES    = 10;
  // Most of a correct run is spent in the phases with heavy idling or
  // stalling.
  localparam int LIMIT_CYCLES    = 100_000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_REPORTS     = 20;
  localparam int PHASE_ITEMS     = 290;
  localparam int THRESHOLD_TICKS = 200;

  // One result as the block should present it on the master stream.
  typedef struct packed {
    logic [RDATA_WIDTH-1:0] read_data;
    logic                   bark_irq;
    logic                   bite_reset;
  } watchdog_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // Fields from bit 0 up: address[11:0], write_data[43:12], zero fill.
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
  // Fields from bit 0 up: command[1:0].
  logic [CMD_WIDTH-1:0]      s_axis_tuser = CMD_TICK;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // Fields from bit 0 up: read_data[20:0], bark_irq[21], bite_reset[22], zero fill.
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

  bark_bite_watchdog_timer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Idle rates in percent, changed by the test phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  // Results predicted for accepted requests, oldest first.
  watchdog_result_t expected_results[$];

  // Our own copy of the watchdog state. Reset is applied once at the start,
  // so the declared zero values match the state right after reset.
  count_t wd_count      = '0;
  logic   wd_enable     = 1'b0;
  count_t wd_bark_limit = '0;
  count_t wd_bite_limit = '0;

  // Applies one request to the state copy and returns the result it causes.
  // The bark and bite levels are taken after the request has been applied.
  function automatic watchdog_result_t watchdog_predict(
    input cmd_t                   cmd,
    input logic [ADDR_WIDTH-1:0]  addr,
    input logic [WDATA_WIDTH-1:0] wdata
  );
    watchdog_result_t res;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        // The counter only moves while enabled and stops at all ones.
        if (wd_enable && wd_count != '1) wd_count = wd_count + count_t'(1);
      end
      CMD_READ: begin
        case (addr)
          OFS_ENABLE: res.read_data = RDATA_WIDTH'(wd_enable);
          OFS_STATUS: res.read_data = RDATA_WIDTH'({wd_count, 1'b0});
          OFS_BARK:   res.read_data = RDATA_WIDTH'(wd_bark_limit);
          OFS_BITE:   res.read_data = RDATA_WIDTH'(wd_bite_limit);
          default:    res.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        // The status offset, unmapped and unaligned offsets take no writes.
        case (addr)
          OFS_RESET:  if (wdata[0]) wd_count = '0;
          OFS_ENABLE: wd_enable = wdata[0];
          OFS_BARK:   wd_bark_limit = wdata[COUNT_WIDTH-1:0];
          OFS_BITE:   wd_bite_limit = wdata[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    res.bark_irq   = wd_enable && (wd_count >= wd_bark_limit);
    res.bite_reset = wd_enable && (wd_count >= wd_bite_limit);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    if (fail_count < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    fail_count++;
  endtask

  // Result checker and request monitor. Both look at the values that stood
  // before the edge, so they do not depend on the order of processes. The
  // result is handled first: the result register stands between a request
  // and its result, so a result never belongs to the request accepted at the same edge.
  always @(posedge clk) begin
    watchdog_result_t exp_res;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result with no request pending, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[RDATA_WIDTH-1:0] !== exp_res.read_data)
            report_mismatch("read_data", 32'(exp_res.read_data),
                            32'(m_axis_tdata[RDATA_WIDTH-1:0]));
          if (m_axis_tdata[RDATA_WIDTH] !== exp_res.bark_irq)
            report_mismatch("bark_irq", 32'(exp_res.bark_irq),
                            32'(m_axis_tdata[RDATA_WIDTH]));
          if (m_axis_tdata[RDATA_WIDTH+1] !== exp_res.bite_reset)
            report_mismatch("bite_reset", 32'(exp_res.bite_reset),
                            32'(m_axis_tdata[RDATA_WIDTH+1]));
          if (m_axis_tdata[OUT_DATA_WIDTH-1:OUT_DATA_BITS] !== '0)
            report_mismatch("zero fill", 32'(0),
                            32'(m_axis_tdata[OUT_DATA_WIDTH-1:OUT_DATA_BITS]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(watchdog_predict(cmd_t'(s_axis_tuser),
                                                    s_axis_tdata[ADDR_WIDTH-1:0],
                                                    s_axis_tdata[ADDR_WIDTH +: WDATA_WIDTH]));
    end
  end

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the run itself.
  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("** bark_bite_watchdog_timer: FAILED **");
    $finish;
  end

  // Sends one request and returns at the edge that accepts it. Valid stays
  // high afterwards, so back-to-back requests need no second assignment.
  task automatic send_request(input cmd_t cmd, input logic [ADDR_WIDTH-1:0] addr,
                              input logic [WDATA_WIDTH-1:0] wdata);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_WIDTH-IN_DATA_BITS){1'b0}}, wdata, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Register map walk plus every corner named for the block: write-only
  // reset register, ignored writes, unaligned offsets, zero times, ticks
  // while disabled, and the outputs dropping on disable.
  task automatic test_register_map();
    send_request(CMD_READ,  OFS_RESET,  32'hFFFF_FFFF);
    send_request(CMD_READ,  OFS_ENABLE, 32'h0);
    send_request(CMD_READ,  OFS_STATUS, 32'h0);
    send_request(CMD_READ,  OFS_BARK,   32'h0);
    send_request(CMD_READ,  OFS_BITE,   32'h0);
    send_request(CMD_READ,  12'h000,    32'h0);
    send_request(CMD_TICK,  12'hFFF,    32'hFFFF_FFFF);
    send_request(CMD_WRITE, OFS_BARK,   32'hFFFF_FFFF);
    send_request(CMD_WRITE, OFS_BITE,   32'hFFF0_0003);
    send_request(CMD_READ,  OFS_BARK,   32'h0);
    send_request(CMD_WRITE, OFS_ENABLE, 32'hFFFF_FFFE);
    send_request(CMD_WRITE, OFS_ENABLE, 32'h0000_0001);
    // A zero bark time fires as soon as the watchdog is enabled.
    send_request(CMD_WRITE, OFS_BARK,   32'h0);
    repeat (3) send_request(CMD_TICK, 12'h000, 32'h0);
    send_request(CMD_READ,  OFS_STATUS, 32'h0);
    send_request(CMD_WRITE, OFS_STATUS, 32'hFFFF_FFFF);
    send_request(CMD_WRITE, OFS_RESET,  32'hFFFF_FFFE);
    send_request(CMD_WRITE, OFS_RESET,  32'h0000_0001);
    send_request(CMD_WRITE, 12'h009,    32'hFFFF_FFFF);
    send_request(CMD_READ,  12'h013,    32'h0);
    send_request(CMD_WRITE, OFS_BITE,   32'h0);
    send_request(CMD_WRITE, OFS_ENABLE, 32'h0);
    send_request(CMD_TICK,  12'h000,    32'h0);
    send_request(CMD_READ,  12'hFFF,    32'h0);
    wait_for_results();
  endtask

  // Counts up across the bark and then the bite time at full rate, so both
  // outputs rise at the exact tick. The bark write carries set upper bits
  // that must be dropped. Saturation at all ones takes over a million ticks
  // and is left to the counter assertions of the block.
  task automatic test_counter_thresholds();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(CMD_WRITE, OFS_BARK,   32'hFFF0_0040);
    send_request(CMD_WRITE, OFS_BITE,   32'h0000_00A0);
    send_request(CMD_WRITE, OFS_RESET,  32'h0000_0001);
    send_request(CMD_WRITE, OFS_ENABLE, 32'h0000_0001);
    repeat (THRESHOLD_TICKS)
      send_request(CMD_TICK, ADDR_WIDTH'($urandom_range(4095)), $urandom());
    send_request(CMD_READ,  OFS_STATUS, 32'h0);
    send_request(CMD_WRITE, OFS_ENABLE, 32'h0);
    send_request(CMD_READ,  OFS_STATUS, 32'h0);
    wait_for_results();
  endtask

  // Mostly mapped offsets, with random ones for the unmapped space.
  function automatic logic [ADDR_WIDTH-1:0] pick_address();
    case ($urandom_range(5))
      0:       return OFS_RESET;
      1:       return OFS_ENABLE;
      2:       return OFS_STATUS;
      3:       return OFS_BARK;
      4:       return OFS_BITE;
      default: return ADDR_WIDTH'($urandom_range(4095));
    endcase
  endfunction

  // Random traffic. Times are kept small most of the time so that the
  // counter crosses them between counter resets.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int                     pick;
    cmd_t                   cmd;
    logic [ADDR_WIDTH-1:0]  addr;
    logic [WDATA_WIDTH-1:0] wdata;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      pick  = $urandom_range(99);
      addr  = pick_address();
      wdata = $urandom();
      if (pick < 45) begin
        cmd = CMD_TICK;
      end else if (pick < 75) begin
        cmd = CMD_READ;
      end else begin
        cmd = CMD_WRITE;
        case (addr)
          OFS_BARK, OFS_BITE: begin
            if ($urandom_range(9) < 8)
              wdata = (wdata & ~32'h000F_FFFF) | $urandom_range(24);
          end
          OFS_ENABLE: wdata[0] = ($urandom_range(9) < 8);
          OFS_RESET:  wdata[0] = ($urandom_range(9) < 4);
          default: ;
        endcase
      end
      send_request(cmd, addr, wdata);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_map();
    test_counter_thresholds();
    test_random_traffic(0, 0);
    test_random_traffic(79, 0);
    test_random_traffic(0, 79);
    test_random_traffic(38, 38);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** bark_bite_watchdog_timer: PASSED **");
    end else begin
      $display("** bark_bite_watchdog_timer: FAILED **");
    end
    $finish;
  end

endmodule
